// File: hw/rtl/dsmf_pkg.sv
// Shared constants, opcodes and types for the dual-side mailbox FIFO.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package dsmf_pkg;

   // Words per side in each send FIFO
   localparam int FIFO_DEPTH = 16;
   // Fill count width: must hold FIFO_DEPTH itself
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int WORD_W     = 32;
   localparam int CTL_W      = 16;

   // Operation codes
   localparam logic [1:0] FUNC_SEND  = 2'd0;
   localparam logic [1:0] FUNC_RECV  = 2'd1;
   localparam logic [1:0] FUNC_WRCTL = 2'd2;
   localparam logic [1:0] FUNC_RDCTL = 2'd3;

   // Control/status register bits and masks
   localparam logic [CTL_W-1:0] CTL_ENABLE    = 16'h8000;
   localparam logic [CTL_W-1:0] CTL_ERROR     = 16'h4000;
   localparam logic [CTL_W-1:0] CTL_WRITABLE  = 16'h8404;
   localparam logic [CTL_W-1:0] CTL_SENDCLEAR = 16'h0008;
   localparam logic [CTL_W-1:0] CTL_SENDEMPTY = 16'h0001;
   localparam logic [CTL_W-1:0] CTL_SENDFULL  = 16'h0002;
   localparam logic [CTL_W-1:0] CTL_RECVEMPTY = 16'h0100;
   localparam logic [CTL_W-1:0] CTL_RECVFULL  = 16'h0200;
   localparam logic [CTL_W-1:0] CTL_RESET     = 16'h0101;
   // Clear error and send flags / clear error and receive flags
   localparam logic [CTL_W-1:0] CTL_KEEP_SEND = 16'hBFFC;
   localparam logic [CTL_W-1:0] CTL_KEEP_RECV = 16'hBCFF;

   // Per-chain command for one cycle
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } chain_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/dsmf_cell.sv
// One storage cell of a mailbox FIFO chain: holds one word.
// Loads a new word or takes its upstream neighbor's word; uses dsmf_pkg.
`default_nettype none

module dsmf_cell (
   input  wire                          clock,
   input  wire                          load_en,
   input  wire                          shift_en,
   input  wire  [dsmf_pkg::WORD_W-1:0]  load_word,
   input  wire  [dsmf_pkg::WORD_W-1:0]  next_word,
   output logic [dsmf_pkg::WORD_W-1:0]  word
);
   import dsmf_pkg::*;

   logic [WORD_W-1:0] word_ff;

   // Load on push, advance toward the head on pop, else hold
   always_ff @(posedge clock) begin
      if (load_en) begin
         word_ff <= load_word;
      end else if (shift_en) begin
         word_ff <= next_word;
      end
   end

   assign word = word_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dsmf_chain.sv
// One send FIFO as a row of dsmf_cell stages; cell 0 is the oldest word.
// Depends on dsmf_pkg and dsmf_cell.
`default_nettype none

module dsmf_chain (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  dsmf_pkg::chain_ctl_type ctl,
   input  wire  [dsmf_pkg::WORD_W-1:0]   push_word,
   output logic [dsmf_pkg::WORD_W-1:0]   head_word,
   output logic [dsmf_pkg::CNT_W-1:0]    count
);
   import dsmf_pkg::*;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [WORD_W-1:0] words [FIFO_DEPTH];

   // Build the row; each cell takes the word of the cell behind it on pop
   for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] upstream;
      if (i == FIFO_DEPTH - 1) begin : g_tail
         assign upstream = words[i];
      end else begin : g_mid
         assign upstream = words[i+1];
      end
      dsmf_cell u_cell (
         .clock     (clock),
         .load_en   (ctl.push && (count_ff == CNT_W'(i))),
         .shift_en  (ctl.pop),
         .load_word (push_word),
         .next_word (upstream),
         .word      (words[i])
      );
   end

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_word = words[0];
   assign count     = count_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dual_side_mailbox_fifo.sv
// Top level of the dual-side mailbox FIFO: control/status registers,
// operation decode and two dsmf_chain send FIFOs. Depends on dsmf_pkg and dsmf_chain.
//
//   Channel   Ports                                   Handshake
//   request   req_func, req_side, req_data            start high, busy low
//   response  rsp_read_data, rsp_control_value        rsp_valid, one cycle
//
// Each transaction is accepted at a clock edge and its response is on the rsp_
// ports for the cycle right after, so a new transaction can be accepted every
// cycle. busy stays low. Synchronous reset clears both FIFOs and sets each
// control register to both-empty, disabled.
// The receiver cannot stall; responses are never held.
`default_nettype none

module dual_side_mailbox_fifo (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [1:0]                    req_func,
   input  wire                           req_side,
   input  wire  [dsmf_pkg::WORD_W-1:0]   req_data,
   output logic                          rsp_valid,
   output logic [dsmf_pkg::WORD_W-1:0]   rsp_read_data,
   output logic [dsmf_pkg::CTL_W-1:0]    rsp_control_value
);
   import dsmf_pkg::*;

   logic                accept;
   logic                loc;
   logic                rem;
   logic [CTL_W-1:0]    ctl_ff [2];
   logic [CTL_W-1:0]    ctl_in [2];
   logic [CTL_W-1:0]    cl;
   logic [CTL_W-1:0]    cr;
   logic [CTL_W-1:0]    wr_val;
   logic [WORD_W-1:0]   rd;
   chain_ctl_type       chain_ctl [2];
   logic [WORD_W-1:0]   head [2];
   logic [CNT_W-1:0]    cnt [2];
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_read_data_ff;
   logic [CTL_W-1:0]    rsp_control_value_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign loc    = req_side;
   assign rem    = ~req_side;
   assign wr_val = req_data[CTL_W-1:0];

   // Send FIFO of each side
   for (genvar s = 0; s < 2; s++) begin : g_side
      dsmf_chain u_chain (
         .clock     (clock),
         .reset     (reset),
         .ctl       (chain_ctl[s]),
         .push_word (req_data),
         .head_word (head[s]),
         .count     (cnt[s])
      );
   end

   // Decode the transaction and compute both control registers
   always_comb begin
      cl           = ctl_ff[loc];
      cr           = ctl_ff[rem];
      rd           = '0;
      chain_ctl[0] = '0;
      chain_ctl[1] = '0;
      case (req_func)
         FUNC_SEND: begin
            if ((cl & CTL_ENABLE) != '0) begin
               if (cnt[loc] == CNT_W'(FIFO_DEPTH)) begin
                  cl = cl | CTL_ERROR;
               end else begin
                  cl = cl & CTL_KEEP_SEND;
                  cr = cr & CTL_KEEP_RECV;
                  chain_ctl[loc].push = accept;
                  if (cnt[loc] == CNT_W'(FIFO_DEPTH - 1)) begin
                     cl = cl | CTL_SENDFULL;
                     cr = cr | CTL_RECVFULL;
                  end
               end
            end
         end
         FUNC_RECV: begin
            if ((cl & CTL_ENABLE) != '0) begin
               if (cnt[rem] == '0) begin
                  cl = cl | CTL_ERROR;
               end else begin
                  cl = cl & CTL_KEEP_RECV;
                  cr = cr & CTL_KEEP_SEND;
                  rd = head[rem];
                  chain_ctl[rem].pop = accept;
                  if (cnt[rem] == CNT_W'(1)) begin
                     cl = cl | CTL_RECVEMPTY;
                     cr = cr | CTL_SENDEMPTY;
                  end
               end
            end
         end
         FUNC_WRCTL: begin
            if ((wr_val & CTL_ERROR) != '0) begin
               cl = cl & ~CTL_ERROR;
            end
            if ((wr_val & CTL_SENDCLEAR) != '0) begin
               chain_ctl[loc].clear = accept;
               cl = (cl | CTL_SENDEMPTY) & ~CTL_SENDFULL;
               cr = (cr | CTL_RECVEMPTY) & ~CTL_RECVFULL;
            end
            cl = (cl & ~CTL_WRITABLE) | (wr_val & CTL_WRITABLE);
         end
         FUNC_RDCTL: begin
         end
         default: begin
         end
      endcase
      ctl_in[0] = loc ? cr : cl;
      ctl_in[1] = loc ? cl : cr;
   end

   // Hold control registers; update on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0]    <= CTL_RESET;
         ctl_ff[1]    <= CTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            ctl_ff[0] <= ctl_in[0];
            ctl_ff[1] <= ctl_in[1];
         end
      end
   end

   // Register the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_data_ff     <= rd;
         rsp_control_value_ff <= cl;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_control_value = rsp_control_value_ff;

   // One response for each accepted transaction, in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after accepted transaction");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response without transaction");

   // Fill counts never pass the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt[0] <= CNT_W'(FIFO_DEPTH)) && (cnt[1] <= CNT_W'(FIFO_DEPTH)))
      else $error("fill count over depth");

   // Empty flags on both sides agree with side 0 fill count
   a_empty_side0: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[0][0] == (cnt[0] == '0)) && (ctl_ff[1][8] == (cnt[0] == '0)))
      else $error("side 0 empty flags out of step with fill count");

   a_empty_side1: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff[1][0] == (cnt[1] == '0)) && (ctl_ff[0][8] == (cnt[1] == '0)))
      else $error("side 1 empty flags out of step with fill count");

   // Nonzero data only comes back from a receive
   a_rd_recv_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_data != '0)) |-> ($past(req_func) == FUNC_RECV))
      else $error("data returned for an operation other than receive");

endmodule

`default_nettype wire
